### rtl/core/sm4_pkg.sv
// Shared constants, types and functions for the SM4 block cipher engine.
// Holds the S-box table, the FK and CK key schedule constants and the linear transforms.
// No dependencies; imported by sm4_round and by the top level of the engine.
`default_nettype none

package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RK_AW       = $clog2(ROUND_COUNT);
  localparam int WORD_W      = 32;
  localparam int BLOCK_W     = 128;
  localparam int CFG_IDX_W   = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [RK_AW-1:0]   rk_addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_DECRYPT  = 3'd4,
    REG_CHAINING = 3'd5
  } cfg_reg_t;

  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t sub_word(input word_t x);
    sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Byte j of CK[i] is (4i + j) * 7 modulo 256.
  function automatic word_t ck_word(input rk_addr_t i);
    word_t      w;
    logic [7:0] b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'((8'({i, 2'b00}) + 8'(j)) * 8'd7);
      w = {w[23:0], b};
    end
    ck_word = w;
  endfunction

  function automatic word_t lin_data(input word_t b);
    lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
               {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  function automatic word_t lin_key(input word_t b);
    lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/sm4_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the expanded round keys of the SM4 engine; no dependencies.
`default_nettype none

module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/sm4_round.sv
// One SM4 round: S-box substitution and linear transform of three words and a key word.
// Serves both the key schedule and the block rounds; depends on sm4_pkg.
`default_nettype none

module sm4_round
  import sm4_pkg::*;
(
  input  wire block_t state_in,
  input  wire word_t  round_key,
  input  wire logic   key_sched,
  output word_t       new_word
);

  word_t mix;
  word_t sub;

  assign mix      = state_in[95:64] ^ state_in[63:32] ^ state_in[31:0] ^ round_key;
  assign sub      = sub_word(mix);
  assign new_word = state_in[127:96] ^ (key_sched ? lin_key(sub) : lin_data(sub));

endmodule

`default_nettype wire

### rtl/core/sm4_block_cipher_ecb_cbc_top.sv
// Top level of the SM4 block cipher engine with ECB and CBC chaining.
// Depends on sm4_pkg, sm4_round and sm4_ram (round key store).
//
//   Port group  Dir  Handshake               Contents
//   in_*        in   in_valid / in_stall     data_high, data_low, start_chain
//   out_*       out  out_valid / out_stall   out_high, out_low
//   cfg_*       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// After acceptance a word passes through ST_PREP, which loads the block and reads
// the first round key, 32 rounds at one round per cycle through the shared
// round unit and the key memory read port, and ST_FINISH. The next word can be
// accepted in the cycle after the result is loaded. After a key write the first
// word first passes through key expansion in ST_EXPAND.
// Reset is synchronous and active low. A finished result waits in the output
// register under out_stall while the next word is accepted and processed.
`default_nettype none

module sm4_block_cipher_ecb_cbc_top
  import sm4_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [63:0]          in_data_high,
  input  wire logic [63:0]          in_data_low,
  input  wire logic                 in_start_chain,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [63:0]          out_high,
  output logic      [63:0]          out_low,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_CRYPT  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  rk_addr_t cnt_r, cnt_nxt;
  logic     keys_ready_r;
  block_t   key_r, iv_r, chain_r, data_r, x_r, x_nxt, out_data_r;
  logic     dec_r, cbc_r, out_valid_r;

  logic     in_acc, cfg_acc, out_load, out_take;
  rk_addr_t rd_step, rk_raddr;
  word_t    rk_rdata, round_key, new_word;
  block_t   blk_in, result;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_high  = out_data_r[127:64];
  assign out_low   = out_data_r[63:0];
  assign out_take  = out_valid_r && !out_stall;

  assign blk_in    = (cbc_r && !dec_r) ? (data_r ^ chain_r) : data_r;
  assign result    = {x_r[31:0], x_r[63:32], x_r[95:64], x_r[127:96]} ^
                     ((cbc_r && dec_r) ? chain_r : '0);
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  assign rd_step   = (state_r == ST_PREP) ? '0 : cnt_r + 1'b1;
  assign rk_raddr  = dec_r ? ~rd_step : rd_step;
  assign round_key = (state_r == ST_EXPAND) ? ck_word(cnt_r) : rk_rdata;

  sm4_round u_round (
    .state_in  (x_r),
    .round_key (round_key),
    .key_sched (state_r == ST_EXPAND),
    .new_word  (new_word)
  );

  sm4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (state_r == ST_EXPAND),
    .waddr (cnt_r),
    .wdata (new_word),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (keys_ready_r) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_EXPAND;
            x_nxt     = key_r ^ {FK0, FK1, FK2, FK3};
          end
        end
      end
      ST_EXPAND: begin
        x_nxt   = {x_r[95:0], new_word};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rk_addr_t'(ROUND_COUNT - 1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        x_nxt     = blk_in;
        cnt_nxt   = '0;
        state_nxt = ST_CRYPT;
      end
      ST_CRYPT: begin
        x_nxt   = {x_r[95:0], new_word};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rk_addr_t'(ROUND_COUNT - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      key_r        <= '0;
      iv_r         <= '0;
      dec_r        <= 1'b0;
      cbc_r        <= 1'b0;
      chain_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_KEY_HIGH: begin
            key_r[127:64] <= cfg_data;
            keys_ready_r  <= 1'b0;
          end
          REG_KEY_LOW: begin
            key_r[63:0]  <= cfg_data;
            keys_ready_r <= 1'b0;
          end
          REG_IV_HIGH:  iv_r[127:64] <= cfg_data;
          REG_IV_LOW:   iv_r[63:0]   <= cfg_data;
          REG_DECRYPT:  dec_r        <= cfg_data[0];
          REG_CHAINING: cbc_r        <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if ((state_r == ST_EXPAND) && (cnt_r == rk_addr_t'(ROUND_COUNT - 1))) begin
        keys_ready_r <= 1'b1;
      end
      if (in_acc && in_start_chain) begin
        chain_r <= iv_r;
      end else if (out_load && cbc_r) begin
        chain_r <= dec_r ? data_r : result;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (in_acc) begin
      data_r <= {in_data_high, in_data_low};
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

### tb/tb_sm4_block_cipher_ecb_cbc_top.sv
// Self-checking testbench for the SM4 block cipher engine in ECB and CBC modes.
// Predicts every result word from a mirror of the key schedule, chain and settings.
// Depends on sm4_pkg for the register index type and on sm4_block_cipher_ecb_cbc_top.
`default_nettype none

module tb_sm4_block_cipher_ecb_cbc_top
  import sm4_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 1650;
  localparam int PRINT_CAP    = 200;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [63:0] ONES64 = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] STD_HI = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] STD_LO = 64'hfedc_ba98_7654_3210;

  localparam logic [31:0] FK_A = 32'ha3b1bac6;
  localparam logic [31:0] FK_B = 32'h56aa3350;
  localparam logic [31:0] FK_C = 32'h677d9197;
  localparam logic [31:0] FK_D = 32'hb27022dc;

  localparam logic [7:0] SBOX_LUT [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        start;
    bit          wait_drain;
  } block_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [63:0]          in_data_high = '0;
  logic [63:0]          in_data_low = '0;
  logic                 in_start_chain = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [63:0]          out_high;
  logic [63:0]          out_low;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  block_word_t  pending_words [$];
  logic [127:0] expected_blocks [$];

  logic [127:0] key_m = '0;
  logic [127:0] iv_m = '0;
  logic [127:0] chain_m = '0;
  logic         dec_m = 1'b0;
  logic         cbc_m = 1'b0;
  logic         sched_valid = 1'b0;
  logic [31:0]  sched [32];

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit cfg_took = 1'b0;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int src_gap = 0;
  int snk_wait = 0;
  int n_sent = 0;
  int n_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sm4_block_cipher_ecb_cbc_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_high   (in_data_high),
    .in_data_low    (in_data_low),
    .in_start_chain (in_start_chain),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_high       (out_high),
    .out_low        (out_low),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] x);
    return {SBOX_LUT[x[31:24]], SBOX_LUT[x[23:16]], SBOX_LUT[x[15:8]], SBOX_LUT[x[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] k [4];
    logic [31:0] ck;
    logic [31:0] b;
    logic [31:0] nk;
    k[0] = key_m[127:96] ^ FK_A;
    k[1] = key_m[95:64] ^ FK_B;
    k[2] = key_m[63:32] ^ FK_C;
    k[3] = key_m[31:0] ^ FK_D;
    for (int i = 0; i < 32; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'(((4 * i + j) * 7) & 255)};
      b  = subst(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
      sched[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
    sched_valid = 1'b1;
  endfunction

  function automatic logic [127:0] run_rounds(input logic [127:0] blk, input logic rev);
    logic [31:0] x0, x1, x2, x3, b, nx, rk;
    {x0, x1, x2, x3} = blk;
    for (int i = 0; i < 32; i++) begin
      rk = sched[rev ? 31 - i : i];
      b  = subst(x1 ^ x2 ^ x3 ^ rk);
      nx = x0 ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
      x0 = x1;
      x1 = x2;
      x2 = x3;
      x3 = nx;
    end
    return {x3, x2, x1, x0};
  endfunction

  function automatic logic [127:0] predict_block(input logic [63:0] hi, input logic [63:0] lo,
                                                 input logic start);
    logic [127:0] din;
    logic [127:0] res;
    din = {hi, lo};
    if (!sched_valid) expand_schedule();
    if (start) chain_m = iv_m;
    if (!cbc_m) begin
      res = run_rounds(din, dec_m);
    end else if (!dec_m) begin
      res = run_rounds(din ^ chain_m, 1'b0);
      chain_m = res;
    end else begin
      res = run_rounds(din, 1'b1) ^ chain_m;
      chain_m = din;
    end
    return res;
  endfunction

  function automatic logic [63:0] pick_half();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ONES64;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch in %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
  endtask

  always @(posedge clk) begin : monitor
    logic [127:0] want;
    in_took  = 1'b0;
    out_took = 1'b0;
    cfg_took = 1'b0;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_took = 1'b1;
        case (cfg_index)
          REG_KEY_HIGH: begin
            key_m[127:64] = cfg_data;
            sched_valid = 1'b0;
          end
          REG_KEY_LOW: begin
            key_m[63:0] = cfg_data;
            sched_valid = 1'b0;
          end
          REG_IV_HIGH:  iv_m[127:64] = cfg_data;
          REG_IV_LOW:   iv_m[63:0] = cfg_data;
          REG_DECRYPT:  dec_m = cfg_data[0];
          REG_CHAINING: cbc_m = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (expected_blocks.size() == 0) begin
          flag_mismatch("unexpected word", out_high, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (out_high !== want[127:64]) flag_mismatch("out_high", out_high, want[127:64]);
          if (out_low !== want[63:0]) flag_mismatch("out_low", out_low, want[63:0]);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        n_taken++;
        expected_blocks.push_back(predict_block(in_data_high, in_data_low, in_start_chain));
      end
    end
  end

  always @(negedge clk) begin : driver
    block_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].wait_drain && expected_blocks.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        in_data_high   <= w.hi;
        in_data_low    <= w.lo;
        in_start_chain <= w.start;
        in_valid       <= 1'b1;
        src_gap = src_idle_on ? $urandom_range(0, 15) : 0;
      end
    end
  end

  always @(negedge clk) begin : sink
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) snk_wait = snk_idle_on ? $urandom_range(0, 15) : 0;
      if (!out_valid) begin
        out_stall <= snk_idle_on ? 1'($urandom_range(0, 1)) : 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_block(input logic [63:0] hi, input logic [63:0] lo, input logic start,
                            input bit drain);
    block_word_t w;
    w.hi = hi;
    w.lo = lo;
    w.start = start;
    w.wait_drain = drain;
    pending_words.push_back(w);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_sent || expected_blocks.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int random_sent;
    int count;
    int msg_len;
    int pos;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // After reset the chain is zero and the key registers are zero.
    write_reg(REG_CHAINING, 64'd1);
    @(posedge clk);
    push_block('0, '0, 1'b0, 1'b0);
    push_block(ONES64, ONES64, 1'b0, 1'b0);
    wait_drained();

    write_reg(REG_KEY_HIGH, STD_HI);
    write_reg(REG_KEY_LOW, STD_LO);
    write_reg(REG_IV_HIGH, 64'h0001_0203_0405_0607);
    write_reg(REG_IV_LOW, 64'h0809_0a0b_0c0d_0e0f);
    write_reg(REG_DECRYPT, 64'd0);
    write_reg(REG_CHAINING, 64'd0);
    @(posedge clk);
    push_block(STD_HI, STD_LO, 1'b0, 1'b0);
    push_block('0, '0, 1'b0, 1'b0);
    push_block(ONES64, ONES64, 1'b0, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b0);
    wait_drained();

    // Switching direction reuses the existing schedule.
    write_reg(REG_DECRYPT, 64'd1);
    @(posedge clk);
    push_block(64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246, 1'b0, 1'b0);
    push_block(ONES64, ONES64, 1'b0, 1'b0);
    wait_drained();

    write_reg(REG_CHAINING, 64'd1);
    @(posedge clk);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b1);
    wait_drained();

    write_reg(REG_DECRYPT, 64'd0);
    @(posedge clk);
    push_block(STD_HI, STD_LO, 1'b1, 1'b0);
    push_block(STD_HI, STD_LO, 1'b0, 1'b0);
    push_block('0, '0, 1'b0, 1'b0);
    push_block(ONES64, ONES64, 1'b1, 1'b0);
    wait_drained();

    // Writes to unused indexes must be ignored; a lone key half forces a new schedule.
    write_reg(REG_SPARE_A, ONES64);
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    write_reg(REG_KEY_LOW, ONES64);
    write_reg(REG_IV_HIGH, ONES64);
    write_reg(REG_IV_LOW, '0);
    @(posedge clk);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    wait_drained();

    write_reg(REG_KEY_HIGH, ONES64);
    write_reg(REG_KEY_LOW, '0);
    write_reg(REG_DECRYPT, ONES64);
    @(posedge clk);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b0);
    push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    wait_drained();

    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_W'(r), pick_half());
      end
      @(posedge clk);
      src_idle_on = $urandom_range(0, 3) != 0;
      snk_idle_on = $urandom_range(0, 3) != 0;
      count = $urandom_range(10, 60);
      pos = 0;
      while (pos < count) begin
        msg_len = $urandom_range(1, 8);
        for (int j = 0; j < msg_len && pos < count; j++) begin
          push_block(pick_half(), pick_half(),
                     ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : (j == 0),
                     $urandom_range(0, 199) == 0 || (random_sent == 0 && pos == count / 2));
          pos++;
          random_sent++;
        end
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (expected_blocks.size() != 0) flag_mismatch("words still expected", '0, '0);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/sm4_pkg.sv
rtl/core/sm4_ram.sv
rtl/core/sm4_round.sv
rtl/core/sm4_block_cipher_ecb_cbc_top.sv
tb/tb_sm4_block_cipher_ecb_cbc_top.sv
